### hw/rtl/bsts_pkg.sv
// ----------------------------------------------------------------------------
// bsts_pkg: shared types and constants of the byte stream text splitter
// Holds widths, character codes, mode and register codes and the record
// bundle that passes from the classifier to the record sequencer.
// ----------------------------------------------------------------------------
package bsts_pkg;

  localparam int MAX_SEP_BYTES = 8;
  localparam int OFFSET_BITS   = 24;
  localparam int WIN_BITS      = 8 * MAX_SEP_BYTES;
  localparam int SHIFT_BITS    = $clog2(WIN_BITS) + 1;
  localparam int SEP_LEN_BITS  = 4;
  localparam int PATTERN_BITS  = 64;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;

  // split modes
  localparam logic [1:0] MODE_SEP    = 2'd0;
  localparam logic [1:0] MODE_LINES  = 2'd1;
  localparam logic [1:0] MODE_FIELDS = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SPLIT_MODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEP_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEP_PATTERN = 2'd2;

  // record kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // record slots of one bundle, in delivery order
  localparam int SLOTS      = 3;
  localparam int SLOT_BITS  = 2;
  localparam int SLOT_BYTE  = 0;
  localparam int SLOT_CLOSE = 1;
  localparam int SLOT_END   = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                   too_long;
    logic [OFFSET_BITS-1:0] count;
    logic [OFFSET_BITS-1:0] length;
    logic [OFFSET_BITS-1:0] start;
    logic                   kind;
  } rec_t;

  typedef struct packed {
    logic [SLOTS-1:0]      valid;
    rec_t [SLOTS-1:0]      rec;
  } bundle_t;

  function automatic logic [OFFSET_BITS-1:0] sat_next(input logic [OFFSET_BITS-1:0] p);
    return (p == OFF_MAX) ? p : p + 1'b1;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] seg_len(input logic [OFFSET_BITS-1:0] s,
                                                     input logic [OFFSET_BITS-1:0] e);
    return (e > s) ? e - s : '0;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_HT) && (b <= CH_CR));
  endfunction

endpackage

### hw/rtl/bsts_front.sv
// ----------------------------------------------------------------------------
// bsts_front: byte classifier and segment tracker
// Holds the configuration registers and the per-text state, takes one byte
// per transfer and builds the bundle of up to three records it causes.
// ----------------------------------------------------------------------------
module bsts_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [bsts_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [bsts_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_byte,
  input  logic                                 in_present,
  input  logic                                 in_end,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output bsts_pkg::bundle_t                    push_data
);

  localparam int OB           = bsts_pkg::OFFSET_BITS;
  localparam int WB           = bsts_pkg::WIN_BITS;
  localparam int SB           = bsts_pkg::SEP_LEN_BITS;
  localparam int SHIFT_BITS_L = bsts_pkg::SHIFT_BITS;

  // configuration
  logic [1:0]                          split_mode;
  logic [SB-1:0]                       sep_length;
  logic [bsts_pkg::PATTERN_BITS-1:0]   sep_pattern;

  // per-text state
  logic [OB-1:0] text_offset, segment_begin, segment_total;
  logic [WB-1:0] match_window;
  logic [SB-1:0] bytes_since_cut;
  logic          pending_cr, in_field, after_terminator, overflow_seen;

  logic [OB-1:0] text_offset_next, segment_begin_next, segment_total_next;
  logic [WB-1:0] match_window_next;
  logic [SB-1:0] bytes_since_cut_next;
  logic          pending_cr_next, in_field_next, after_terminator_next;
  logic          overflow_seen_next;

  logic          accept;
  bsts_pkg::bundle_t bundle;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && (bundle.valid != '0);
  assign push_data  = bundle;

  // Work out the effect of one item on the state and the records it causes
  always_comb begin
    logic [OB-1:0]           pos;
    logic [SB-1:0]           len;
    logic [SHIFT_BITS_L-1:0] sh;
    logic [WB-1:0]           shifted, mask;
    logic [OB:0]             p1, end_wide;
    logic [OB-1:0]           seg_end;
    logic                    hit;

    text_offset_next      = text_offset;
    segment_begin_next    = segment_begin;
    segment_total_next    = segment_total;
    match_window_next     = match_window;
    bytes_since_cut_next  = bytes_since_cut;
    pending_cr_next       = pending_cr;
    in_field_next         = in_field;
    after_terminator_next = after_terminator;
    overflow_seen_next    = overflow_seen;
    bundle                = '0;

    pos      = text_offset;
    len      = (sep_length > SB'(bsts_pkg::MAX_SEP_BYTES)) ?
               SB'(bsts_pkg::MAX_SEP_BYTES) : sep_length;
    sh       = SHIFT_BITS_L'(WB) - SHIFT_BITS_L'({len, 3'b000});
    p1       = {1'b0, pos} + 1'b1;
    end_wide = (p1 >= (OB+1)'(len)) ? p1 - (OB+1)'(len) : '0;
    seg_end  = end_wide[OB-1:0];
    shifted  = '0;
    mask     = '0;
    hit      = 1'b0;

    // Byte part
    if (in_present) begin
      if (text_offset == bsts_pkg::OFF_MAX) begin
        overflow_seen_next = 1'b1;
      end else begin
        text_offset_next = text_offset + 1'b1;
      end

      case (split_mode)
        bsts_pkg::MODE_SEP: begin
          match_window_next = {in_byte, match_window[WB-1:8]};
          if (bytes_since_cut < SB'(bsts_pkg::MAX_SEP_BYTES)) begin
            bytes_since_cut_next = bytes_since_cut + 1'b1;
          end
          shifted = match_window_next >> sh;
          mask    = (len == SB'(bsts_pkg::MAX_SEP_BYTES)) ? '1 :
                    (WB'(1) << {len, 3'b000}) - WB'(1);
          hit     = (len != '0) && (bytes_since_cut_next >= len) &&
                    (shifted == (sep_pattern[WB-1:0] & mask));
          if (hit) begin
            if (segment_total_next == bsts_pkg::OFF_MAX) begin
              overflow_seen_next = 1'b1;
            end else begin
              segment_total_next = segment_total_next + 1'b1;
            end
            bundle.valid[bsts_pkg::SLOT_BYTE] = 1'b1;
            bundle.rec[bsts_pkg::SLOT_BYTE]   = '{too_long: overflow_seen_next,
                                                  count: segment_total_next,
                                                  length: bsts_pkg::seg_len(segment_begin,
                                                                            seg_end),
                                                  start: segment_begin,
                                                  kind: bsts_pkg::KIND_SEGMENT};
            segment_begin_next   = bsts_pkg::sat_next(pos);
            bytes_since_cut_next = '0;
          end
        end
        bsts_pkg::MODE_LINES: begin
          if (pending_cr && (in_byte == bsts_pkg::CH_LF)) begin
            // absorb the LF of a CRLF pair
            pending_cr_next    = 1'b0;
            segment_begin_next = bsts_pkg::sat_next(pos);
          end else if ((in_byte == bsts_pkg::CH_CR) || (in_byte == bsts_pkg::CH_LF)) begin
            if (segment_total_next == bsts_pkg::OFF_MAX) begin
              overflow_seen_next = 1'b1;
            end else begin
              segment_total_next = segment_total_next + 1'b1;
            end
            bundle.valid[bsts_pkg::SLOT_BYTE] = 1'b1;
            bundle.rec[bsts_pkg::SLOT_BYTE]   = '{too_long: overflow_seen_next,
                                                  count: segment_total_next,
                                                  length: bsts_pkg::seg_len(segment_begin, pos),
                                                  start: segment_begin,
                                                  kind: bsts_pkg::KIND_SEGMENT};
            segment_begin_next    = bsts_pkg::sat_next(pos);
            pending_cr_next       = (in_byte == bsts_pkg::CH_CR);
            after_terminator_next = 1'b1;
          end else begin
            pending_cr_next       = 1'b0;
            after_terminator_next = 1'b0;
          end
        end
        bsts_pkg::MODE_FIELDS: begin
          if (bsts_pkg::is_space(in_byte)) begin
            if (in_field) begin
              if (segment_total_next == bsts_pkg::OFF_MAX) begin
                overflow_seen_next = 1'b1;
              end else begin
                segment_total_next = segment_total_next + 1'b1;
              end
              bundle.valid[bsts_pkg::SLOT_BYTE] = 1'b1;
              bundle.rec[bsts_pkg::SLOT_BYTE]   = '{too_long: overflow_seen_next,
                                                    count: segment_total_next,
                                                    length: bsts_pkg::seg_len(segment_begin,
                                                                              pos),
                                                    start: segment_begin,
                                                    kind: bsts_pkg::KIND_SEGMENT};
            end
            in_field_next = 1'b0;
          end else if (!in_field) begin
            segment_begin_next = pos;
            in_field_next      = 1'b1;
          end
        end
        default: begin
          // unused mode: count bytes only
        end
      endcase
    end

    // Close part: final segment, end record, then clear the text state
    if (in_end) begin
      if (((split_mode == bsts_pkg::MODE_SEP)) ||
          ((split_mode == bsts_pkg::MODE_LINES) && !after_terminator_next) ||
          ((split_mode == bsts_pkg::MODE_FIELDS) && in_field_next)) begin
        if (segment_total_next == bsts_pkg::OFF_MAX) begin
          overflow_seen_next = 1'b1;
        end else begin
          segment_total_next = segment_total_next + 1'b1;
        end
        bundle.valid[bsts_pkg::SLOT_CLOSE] = 1'b1;
        bundle.rec[bsts_pkg::SLOT_CLOSE]   = '{too_long: overflow_seen_next,
                                               count: segment_total_next,
                                               length: bsts_pkg::seg_len(segment_begin_next,
                                                                         text_offset_next),
                                               start: segment_begin_next,
                                               kind: bsts_pkg::KIND_SEGMENT};
      end
      bundle.valid[bsts_pkg::SLOT_END] = 1'b1;
      bundle.rec[bsts_pkg::SLOT_END]   = '{too_long: overflow_seen_next,
                                           count: segment_total_next,
                                           length: '0,
                                           start: '0,
                                           kind: bsts_pkg::KIND_END};
      text_offset_next      = '0;
      segment_begin_next    = '0;
      segment_total_next    = '0;
      match_window_next     = '0;
      bytes_since_cut_next  = '0;
      pending_cr_next       = 1'b0;
      in_field_next         = 1'b0;
      after_terminator_next = 1'b1;
      overflow_seen_next    = 1'b0;
    end
  end

  // Hold configuration; take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      split_mode  <= bsts_pkg::MODE_SEP;
      sep_length  <= '0;
      sep_pattern <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bsts_pkg::REG_SPLIT_MODE:  split_mode  <= cfg_data[1:0];
        bsts_pkg::REG_SEP_LENGTH:  sep_length  <= cfg_data[SB-1:0];
        bsts_pkg::REG_SEP_PATTERN: sep_pattern <= cfg_data[bsts_pkg::PATTERN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance the text state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      text_offset      <= '0;
      segment_begin    <= '0;
      segment_total    <= '0;
      match_window     <= '0;
      bytes_since_cut  <= '0;
      pending_cr       <= 1'b0;
      in_field         <= 1'b0;
      after_terminator <= 1'b1;
      overflow_seen    <= 1'b0;
    end else if (accept) begin
      text_offset      <= text_offset_next;
      segment_begin    <= segment_begin_next;
      segment_total    <= segment_total_next;
      match_window     <= match_window_next;
      bytes_since_cut  <= bytes_since_cut_next;
      pending_cr       <= pending_cr_next;
      in_field         <= in_field_next;
      after_terminator <= after_terminator_next;
      overflow_seen    <= overflow_seen_next;
    end
  end

endmodule

### hw/rtl/bsts_queue.sv
// ----------------------------------------------------------------------------
// bsts_queue: record bundle queue
// Short first-in first-out store of record bundles between the classifier
// and the record sequencer, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module bsts_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  bsts_pkg::bundle_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output bsts_pkg::bundle_t pop_data
);

  localparam int PB = bsts_pkg::QPTR_BITS;

  bsts_pkg::bundle_t entries [bsts_pkg::QUEUE_DEPTH];
  logic [PB-1:0]     wr_ptr, rd_ptr;
  logic [PB:0]       fill;
  logic              do_push, do_pop;

  assign push_ready = (fill != (PB+1)'(bsts_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store a bundle at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/bsts_back.sv
// ----------------------------------------------------------------------------
// bsts_back: record sequencer
// Walks the valid slots of the head bundle into the output register, one
// record per cycle unless the output stalls; marks each bundle's final record.
// ----------------------------------------------------------------------------
module bsts_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  bsts_pkg::bundle_t   pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsts_pkg::rec_t      out_rec,
  output logic                out_last
);

  localparam int NS = bsts_pkg::SLOTS;

  logic                           started;
  logic [NS-1:0]                  rem;
  logic [NS-1:0]                  cur, rest;
  logic [bsts_pkg::SLOT_BITS-1:0] sel;
  logic                           load_out;

  // Pick the earliest slot still to deliver
  always_comb begin
    cur = started ? rem : pop_data.valid;
    sel = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (cur[i]) begin
        sel = bsts_pkg::SLOT_BITS'(i);
      end
    end
    rest      = cur;
    rest[sel] = 1'b0;
  end

  assign load_out  = !out_valid || out_ready;
  assign pop_ready = load_out && (rest == '0);

  // Load the output register and track the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
      rem       <= '0;
    end else if (load_out) begin
      out_valid <= pop_valid;
      if (pop_valid) begin
        started <= (rest != '0);
        rem     <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && pop_valid) begin
      out_rec  <= pop_data.rec[sel];
      out_last <= (rest == '0);
    end
  end

`ifndef SYNTHESIS
  // a partly delivered bundle stays at the queue head
  assert property (@(posedge clk) disable iff (rst) started |-> pop_valid)
    else $error("partly delivered bundle left the queue");

  // a partly delivered bundle still has records to deliver
  assert property (@(posedge clk) disable iff (rst) started |-> (rem != '0))
    else $error("sequencer started with nothing left");

  // an end record always closes its bundle
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && (out_rec.kind == bsts_pkg::KIND_END)) |-> out_last)
    else $error("end record not marked last");

  // a bundle is popped only on its final record
  assert property (@(posedge clk) disable iff (rst)
                   (pop_valid && pop_ready) |=> (out_valid && out_last))
    else $error("bundle popped before final record");
`endif

endmodule

### hw/rtl/byte_stream_text_splitter.sv
// ----------------------------------------------------------------------------
// byte_stream_text_splitter: text segment finder over a byte stream
// Splits a text by separator, by line ends or by whitespace and reports each
// segment as start offset and length, then an end record per text.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one text byte per transfer. s_tuser is high when
//   s_tdata carries a byte; s_tlast closes the text (a transfer with
//   s_tuser low and s_tlast high is an empty text or a bare close).
//   Master channel m_*: one record per transfer. m_tuser is the record kind
//   (segment or end of text), m_tlast marks the final record caused by one
//   input transfer.
//   Configuration: write split mode, separator length and separator bytes
//   through cfg_wr_en/cfg_index/cfg_data between texts.
//   Delivery: a record can be taken on the master channel once it has passed
//   through the queue and then the output register after the byte transfer
//   that causes it. The classifier takes one byte per cycle while the queue
//   has room; the record sequencer sends one record per cycle while m_tready
//   is high, and a four-bundle queue absorbs the records of one item.
//   Reset clears all text state and the configuration (separator mode,
//   empty separator). When m_tready is low the output record holds, the
//   queue fills and s_tready drops once it is full.
// ----------------------------------------------------------------------------
module byte_stream_text_splitter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [bsts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bsts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // text_byte
  input  logic                                s_tuser,  // byte_present
  input  logic                                s_tlast,  // text_end
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [79:0]                         m_tdata,  // seg_start, seg_length,
                                                        // seg_count, too_long, zero pad
  output logic                                m_tuser,  // record_kind
  output logic                                m_tlast   // last_result
);

  logic              push_valid, push_ready, pop_valid, pop_ready;
  bsts_pkg::bundle_t push_data, pop_data;
  bsts_pkg::rec_t    out_rec;

  bsts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_present (s_tuser),
    .in_end     (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bsts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bsts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec),
    .out_last  (m_tlast)
  );

  // Pack the record fields, lowest field first
  assign m_tdata = {7'b0, out_rec.too_long, out_rec.count, out_rec.length, out_rec.start};
  assign m_tuser = out_rec.kind;

endmodule

### tb/sv/text_split_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_split_monitor: record predictor and comparator for the text splitter
// Watches configuration writes and both stream channels, works out the
// segment and end records that each accepted text transfer must produce,
// and compares every accepted output record field by field in order.
// ----------------------------------------------------------------------------
module text_split_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [bsts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bsts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // text_byte
  input  logic                                s_tuser,  // byte_present
  input  logic                                s_tlast,  // text_end
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [79:0]                         m_tdata,  // seg_start, seg_length,
                                                        // seg_count, too_long, zero pad
  input  logic                                m_tuser,  // record_kind
  input  logic                                m_tlast,  // last_result
  output int                                  fail_count,
  output int                                  records_due
);

  import bsts_pkg::*;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef struct packed {
    logic    kind;
    offset_t start;
    offset_t length;
    offset_t count;
    logic    too_long;
    logic    last;
  } seg_rec_t;

  // configuration copy
  logic [1:0]              mode;
  logic [SEP_LEN_BITS-1:0] sep_len;
  logic [PATTERN_BITS-1:0] sep_pat;

  // per-text state
  offset_t     txt_off;
  offset_t     seg_begin;
  offset_t     seg_total;
  logic [63:0] window;
  logic [3:0]  since_cut;
  logic        cr_pending;
  logic        field_open;
  logic        after_term;
  logic        ovf;

  seg_rec_t expected_recs[$];
  seg_rec_t step_recs[3];
  int       step_n;
  seg_rec_t got;
  seg_rec_t want;
  int       mismatches;
  int       rec_no;

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("%0t ns: record %0d: %s is 0x%0h, expected 0x%0h",
             $time, rec_no, what, seen, wanted);
    mismatches++;
  endtask

  function automatic offset_t step_off(input offset_t p);
    return (p == OFF_MAX) ? p : p + 1'b1;
  endfunction

  function automatic logic blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_HT && b <= CH_CR);
  endfunction

  task automatic clear_text_state();
    txt_off    = '0;
    seg_begin  = '0;
    seg_total  = '0;
    window     = '0;
    since_cut  = '0;
    cr_pending = 1'b0;
    field_open = 1'b0;
    after_term = 1'b1;
    ovf        = 1'b0;
  endtask

  task automatic add_record(input logic kind, input offset_t start, input offset_t len);
    if (step_n < 3) begin
      step_recs[step_n] = '{kind, start, len, seg_total, ovf, 1'b0};
      step_n++;
    end
  endtask

  // count the segment (saturating) and queue its record
  task automatic cut_segment(input offset_t start, input offset_t stop);
    offset_t len;
    len = (stop > start) ? stop - start : '0;
    if (seg_total == OFF_MAX) ovf = 1'b1;
    else seg_total++;
    add_record(KIND_SEGMENT, start, len);
  endtask

  task automatic take_text_byte(input logic [7:0] b);
    offset_t         pos;
    offset_t         stop;
    logic [OFFSET_BITS:0] pos1;
    logic [63:0]     mask;
    int              n;
    pos = txt_off;
    if (txt_off == OFF_MAX) ovf = 1'b1;
    else txt_off++;
    case (mode)
      MODE_SEP: begin
        n = (sep_len > MAX_SEP_BYTES) ? MAX_SEP_BYTES : int'(sep_len);
        window = {b, window[63:8]};
        if (since_cut < MAX_SEP_BYTES) since_cut++;
        if (n != 0) begin
          mask = (n == 8) ? '1 : (64'd1 << (8 * n)) - 64'd1;
          if (since_cut >= n && (window >> (64 - 8 * n)) == (sep_pat & mask)) begin
            pos1 = {1'b0, pos} + 1'b1;
            stop = (pos1 >= n) ? offset_t'(pos1 - n) : '0;
            cut_segment(seg_begin, stop);
            seg_begin = step_off(pos);
            since_cut = '0;
          end
        end
      end
      MODE_LINES: begin
        if (cr_pending && b == CH_LF) begin
          // second half of CRLF: absorb
          cr_pending = 1'b0;
          seg_begin  = step_off(pos);
        end else begin
          cr_pending = 1'b0;
          if (b == CH_CR || b == CH_LF) begin
            cut_segment(seg_begin, pos);
            seg_begin  = step_off(pos);
            cr_pending = (b == CH_CR);
            after_term = 1'b1;
          end else begin
            after_term = 1'b0;
          end
        end
      end
      MODE_FIELDS: begin
        if (blank(b)) begin
          if (field_open) cut_segment(seg_begin, pos);
          field_open = 1'b0;
        end else if (!field_open) begin
          seg_begin  = pos;
          field_open = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic close_text();
    case (mode)
      MODE_SEP:    cut_segment(seg_begin, txt_off);
      MODE_LINES:  if (!after_term) cut_segment(seg_begin, txt_off);
      MODE_FIELDS: if (field_open) cut_segment(seg_begin, txt_off);
      default: ;
    endcase
    add_record(KIND_END, '0, '0);
    clear_text_state();
  endtask

  // work out the records of one accepted text transfer
  task automatic predict_item(input logic [7:0] b, input logic present, input logic close);
    step_n = 0;
    if (present) take_text_byte(b);
    if (close) close_text();
    if (step_n > 0) step_recs[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_recs.push_back(step_recs[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode    = MODE_SEP;
      sep_len = '0;
      sep_pat = '0;
      clear_text_state();
      expected_recs.delete();
      mismatches = 0;
      rec_no     = 0;
    end else begin
      // predict from the input transfer, using the configuration before this edge
      if (s_tvalid && s_tready) predict_item(s_tdata, s_tuser, s_tlast);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SPLIT_MODE:  mode    = cfg_data[1:0];
          REG_SEP_LENGTH:  sep_len = cfg_data[SEP_LEN_BITS-1:0];
          REG_SEP_PATTERN: sep_pat = cfg_data[PATTERN_BITS-1:0];
          default: ;
        endcase
      end
      // compare the output transfer with the oldest expectation
      if (m_tvalid && m_tready) begin
        got.kind     = m_tuser;
        got.start    = m_tdata[OFFSET_BITS-1:0];
        got.length   = m_tdata[2*OFFSET_BITS-1:OFFSET_BITS];
        got.count    = m_tdata[3*OFFSET_BITS-1:2*OFFSET_BITS];
        got.too_long = m_tdata[3*OFFSET_BITS];
        got.last     = m_tlast;
        if (expected_recs.size() == 0) begin
          report_mismatch("unexpected record, kind", 32'(got.kind), 32'(got.kind));
        end else begin
          want = expected_recs.pop_front();
          if (got.kind != want.kind)
            report_mismatch("record_kind", 32'(got.kind), 32'(want.kind));
          if (got.start != want.start)
            report_mismatch("seg_start", 32'(got.start), 32'(want.start));
          if (got.length != want.length)
            report_mismatch("seg_length", 32'(got.length), 32'(want.length));
          if (got.count != want.count)
            report_mismatch("seg_count", 32'(got.count), 32'(want.count));
          if (got.too_long != want.too_long)
            report_mismatch("too_long", 32'(got.too_long), 32'(want.too_long));
          if (got.last != want.last)
            report_mismatch("last_result", 32'(got.last), 32'(want.last));
        end
        rec_no++;
      end
    end
    fail_count  <= mismatches;
    records_due <= expected_recs.size();
  end

endmodule

### tb/sv/tb_byte_stream_text_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stream_text_splitter: stimulus and verdict for the text splitter
// Runs directed texts over every split mode and the corner cases, then random
// texts under random configurations with random gaps and stalls on both
// channels, including one long output stall; the monitor checks the records.
// ----------------------------------------------------------------------------
module tb_byte_stream_text_splitter;

  import bsts_pkg::*;

  localparam logic [1:0] MODE_COUNT_ONLY = 2'd3;
  localparam int         WATCHDOG_LIMIT  = 5000;
  localparam int         HOLD_CYCLES     = 150;
  localparam int         RANDOM_ITEMS    = 330;

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [7:0]               s_tdata;  // text_byte
  logic                     s_tuser;  // byte_present
  logic                     s_tlast;  // text_end
  logic                     m_tvalid;
  logic                     m_tready;
  logic [79:0]              m_tdata;  // seg_start, seg_length, seg_count, too_long, zero pad
  logic                     m_tuser;  // record_kind
  logic                     m_tlast;  // last_result
  int                       fail_count;
  int                       records_due;

  logic                     calm;
  logic                     hold_req;
  int                       items_done;
  int                       quiet_cycles;
  logic [SEP_LEN_BITS-1:0]  cur_len;
  logic [PATTERN_BITS-1:0]  cur_pat;

  byte_stream_text_splitter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  text_split_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .records_due(records_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // output side: random stalls, or a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one text transfer, with random gaps, and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic present, input logic close);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 34) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= present;
    s_tlast  <= close;
    do @(posedge clk); while (!s_tready);
    if (present || close) items_done++;
  endtask

  // drop valid, wait for every expected record, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (records_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] md, input logic [SEP_LEN_BITS-1:0] len,
                            input logic [PATTERN_BITS-1:0] pat);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SPLIT_MODE;
    cfg_data  <= {$urandom(), $urandom()} & ~64'h3 | 64'(md);
    @(negedge clk);
    cfg_index <= REG_SEP_LENGTH;
    cfg_data  <= {$urandom(), $urandom()} & ~64'hF | 64'(len);
    @(negedge clk);
    cfg_index <= REG_SEP_PATTERN;
    cfg_data  <= pat;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_len = len;
    cur_pat = pat;
  endtask

  // text byte biased towards separator bytes, line ends and whitespace
  function automatic logic [7:0] pick_byte();
    int r;
    int span;
    r    = $urandom_range(0, 9);
    span = (cur_len == 0) ? 1 : ((cur_len > MAX_SEP_BYTES) ? MAX_SEP_BYTES : cur_len);
    case (r)
      0, 1, 2, 3: return cur_pat[8 * $urandom_range(0, span - 1) +: 8];
      4:          return CH_CR;
      5:          return CH_LF;
      6:          return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one text: bytes, the odd empty transfer, and a close on the last byte or bare
  task automatic send_text(input int len);
    logic close_on_byte;
    close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic logic [PATTERN_BITS-1:0] pick_pattern();
    logic [PATTERN_BITS-1:0] pat;
    case ($urandom_range(0, 9))
      0:       pat = '1;
      1:       pat = '0;
      default: begin
        pat = {$urandom(), $urandom()};
        for (int i = 0; i < MAX_SEP_BYTES; i++)
          if ($urandom_range(0, 1)) pat[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
      end
    endcase
    return pat;
  endfunction

  function automatic logic [SEP_LEN_BITS-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 4'd8;
      2:       return 4'($urandom_range(9, 15));
      default: return 4'($urandom_range(1, 7));
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(0, 9))
      4, 5:    return MODE_LINES;
      6, 7:    return MODE_FIELDS;
      8:       return MODE_COUNT_ONLY;
      default: return MODE_SEP;
    endcase
  endfunction

  initial begin
    int phase;
    int texts;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    s_tlast      = 1'b0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    items_done   = 0;
    quiet_cycles = 0;
    cur_len      = '0;
    cur_pat      = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: empty separator, empty text then a whole text
    send_item(8'h00, 1'b0, 1'b1);
    send_item("h", 1'b1, 1'b0);
    send_item("i", 1'b1, 1'b1);

    // two-byte separator, leading and trailing match
    wait_drained();
    set_config(MODE_SEP, 4'd2, 64'hA5A5_A5A5_A5A5_6261);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("x", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b1);

    // lines: CRLF absorbed, bare LF gives an empty line, no trailing line
    wait_drained();
    set_config(MODE_LINES, 4'd0, 64'h0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item(CH_CR, 1'b1, 1'b0);
    send_item(CH_LF, 1'b1, 1'b0);
    send_item(CH_LF, 1'b1, 1'b1);

    // switch from lines to fields inside a text
    wait_drained();
    send_item("p", 1'b1, 1'b0);
    send_item(CH_SPACE, 1'b1, 1'b0);
    wait_drained();
    set_config(MODE_FIELDS, 4'd0, 64'h0);
    send_item("q", 1'b1, 1'b1);

    // fields around leading and inner whitespace
    send_item(CH_SPACE, 1'b1, 1'b0);
    send_item("x", 1'b1, 1'b0);
    send_item(CH_HT, 1'b1, 1'b0);
    send_item("y", 1'b1, 1'b1);

    // unused mode gives only the end record
    wait_drained();
    set_config(MODE_COUNT_ONLY, 4'd3, 64'h0);
    send_item("z", 1'b1, 1'b1);

    // oversized length acts as eight, extreme byte values, match on the closing byte
    wait_drained();
    set_config(MODE_SEP, 4'd15, 64'hFF00_FF00_FF00_FF00);
    for (int i = 0; i < 8; i++) send_item((i % 2) ? 8'hFF : 8'h00, 1'b1, i == 7);

    // random phases
    items_done = 0;
    phase      = 0;
    while (items_done < RANDOM_ITEMS) begin
      wait_drained();
      calm = (phase == 1);
      if (phase == 2) begin
        // long output hold-off while fields keep coming
        set_config(MODE_FIELDS, pick_length(), pick_pattern());
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_item((i % 2) ? CH_SPACE : "w", 1'b1, i == 39);
      end else begin
        set_config(pick_mode(), pick_length(), pick_pattern());
      end
      texts = $urandom_range(2, 5);
      for (int t = 0; t < texts; t++)
        send_text(($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16));
      phase++;
    end

    wait_drained();
    calm = 1'b0;
    repeat (20) @(posedge clk);
    if (fail_count == 0 && records_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
